[rtl/data_run_list_decoder_assert.svh]
// Assertion macros shared by the run-list decoder RTL.
`ifndef DATA_RUN_LIST_DECODER_ASSERT_SVH
`define DATA_RUN_LIST_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DRLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DRLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/drld_pkg.sv]
// Shared types and constants for the run-list decoder.
package drld_pkg;

    localparam int unsigned MAX_FIELD_BYTES = 8;
    localparam int unsigned IDX_W           = 21;
    localparam int unsigned CB_W            = 22;
    localparam int unsigned WORD_W          = 64;
    localparam int unsigned CFG_IDX_W       = 2;

    localparam logic [IDX_W-1:0] CAP_DEFAULT = IDX_W'(1 << 20);
    localparam logic [IDX_W-1:0] IDX_MAX     = {IDX_W{1'b1}};

    localparam logic [3:0] MAX_FIELD = 4'(MAX_FIELD_BYTES);
    localparam logic [3:0] NIB_MASK  = 4'hF;

    localparam logic [2:0] ST_EXTENT    = 3'd0;
    localparam logic [2:0] ST_END       = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_CAP       = 3'd3;
    localparam logic [2:0] ST_LIMIT     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_CAP      = 2'd2;

    // sideband that travels with a result through the scaling stages
    typedef struct packed {
        logic       ext;
        logic       sparse;
        logic [2:0] status;
        logic       newlist;
    } t_tag;

    typedef struct packed {
        t_tag              tag;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] clus;
    } t_item;

endpackage

[rtl/drld_front.sv]
// Byte parser: header/length/offset decode, cluster tracking, result slot.
module drld_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_beat,
    input  logic [7:0]                    i_run_byte,
    input  logic                          i_list_start,
    input  logic [drld_pkg::IDX_W-1:0]    i_byte_cap,
    input  logic                          i_take,
    output logic                          o_valid,
    output drld_pkg::t_item               o_item
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_OFFSET = 2'd2
    } t_phase;

    t_phase                       r_phase, e_phase, n_phase;
    logic [3:0]                   r_ls, e_ls, n_ls;
    logic [3:0]                   r_os, e_os, n_os;
    logic [3:0]                   r_fi, e_fi, n_fi;
    logic [63:0]                  r_len, e_len, n_len;
    logic [63:0]                  r_off, e_off, n_off;
    logic [63:0]                  r_cc, e_cc, n_cc;
    logic [drld_pkg::IDX_W-1:0]   r_idx, e_idx, n_idx;
    logic                         r_fin, e_fin, n_fin;
    logic                         r_newlist;
    logic                         r_valid;
    drld_pkg::t_item              r_item;

    logic                         emit;
    drld_pkg::t_item              n_item;
    logic [drld_pkg::IDX_W-1:0]   idx_inc;
    logic [drld_pkg::IDX_W-1:0]   cap;
    logic [3:0]                   fi_inc;
    logic [63:0]                  len_merge;
    logic [63:0]                  off_merge;
    logic [63:0]                  off_full;

    always_comb begin
        e_phase = i_list_start ? PH_HEADER : r_phase;
        e_ls    = i_list_start ? 4'd0 : r_ls;
        e_os    = i_list_start ? 4'd0 : r_os;
        e_fi    = i_list_start ? 4'd0 : r_fi;
        e_len   = i_list_start ? 64'd0 : r_len;
        e_off   = i_list_start ? 64'd0 : r_off;
        e_cc    = i_list_start ? 64'd0 : r_cc;
        e_idx   = i_list_start ? '0 : r_idx;
        e_fin   = i_list_start ? 1'b0 : r_fin;

        idx_inc = (e_idx == drld_pkg::IDX_MAX) ? e_idx : e_idx + 1'b1;
        cap     = (i_byte_cap == '0) ? drld_pkg::CAP_DEFAULT : i_byte_cap;
        fi_inc  = e_fi + 4'd1;

        for (int k = 0; k < 8; k++) begin
            if (e_fi[2:0] == 3'(k)) begin
                len_merge[8*k +: 8] = e_len[8*k +: 8] | i_run_byte;
                off_merge[8*k +: 8] = e_off[8*k +: 8] | i_run_byte;
                off_full[8*k +: 8]  = e_off[8*k +: 8] | i_run_byte;
            end else if (e_fi[2:0] > 3'(k)) begin
                len_merge[8*k +: 8] = e_len[8*k +: 8];
                off_merge[8*k +: 8] = e_off[8*k +: 8];
                off_full[8*k +: 8]  = e_off[8*k +: 8];
            end else begin
                len_merge[8*k +: 8] = e_len[8*k +: 8];
                off_merge[8*k +: 8] = e_off[8*k +: 8];
                off_full[8*k +: 8]  = {8{i_run_byte[7]}};
            end
        end

        n_phase = e_phase;
        n_ls    = e_ls;
        n_os    = e_os;
        n_fi    = e_fi;
        n_len   = e_len;
        n_off   = e_off;
        n_cc    = e_cc;
        n_idx   = e_idx;
        n_fin   = e_fin;

        emit           = 1'b0;
        n_item.tag     = '{ext: 1'b0, sparse: 1'b0, status: drld_pkg::ST_EXTENT,
                           newlist: r_newlist | i_list_start};
        n_item.len     = 64'd0;
        n_item.clus    = 64'd0;

        if (!e_fin) begin
            case (e_phase)
                PH_LENGTH: begin
                    n_idx = idx_inc;
                    n_len = len_merge;
                    if (fi_inc < e_ls) begin
                        n_fi = fi_inc;
                    end else begin
                        n_fi = 4'd0;
                        if (e_os == 4'd0) begin
                            emit              = 1'b1;
                            n_item.tag.ext    = 1'b1;
                            n_item.tag.sparse = 1'b1;
                            n_item.len        = len_merge;
                            n_phase           = PH_HEADER;
                        end else begin
                            n_phase = PH_OFFSET;
                        end
                    end
                end
                PH_OFFSET: begin
                    n_idx = idx_inc;
                    n_off = off_merge;
                    n_fi  = fi_inc;
                    if (fi_inc >= e_os) begin
                        n_off          = off_full;
                        n_cc           = e_cc + off_full;
                        n_fi           = 4'd0;
                        n_phase        = PH_HEADER;
                        emit           = 1'b1;
                        n_item.tag.ext = 1'b1;
                        n_item.len     = e_len;
                        n_item.clus    = e_cc + off_full;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                    if (e_idx >= cap) begin
                        n_fin             = 1'b1;
                        emit              = 1'b1;
                        n_item.tag.status = drld_pkg::ST_CAP;
                    end else begin
                        n_idx = idx_inc;
                        if (i_run_byte == 8'd0) begin
                            n_fin             = 1'b1;
                            emit              = 1'b1;
                            n_item.tag.status = drld_pkg::ST_END;
                        end else begin
                            n_ls = i_run_byte[3:0] & drld_pkg::NIB_MASK;
                            n_os = i_run_byte[7:4] & drld_pkg::NIB_MASK;
                            if (n_ls == 4'd0 || n_ls > drld_pkg::MAX_FIELD ||
                                n_os > drld_pkg::MAX_FIELD) begin
                                n_fin             = 1'b1;
                                emit              = 1'b1;
                                n_item.tag.status = drld_pkg::ST_MALFORMED;
                            end else begin
                                n_fi    = 4'd0;
                                n_len   = 64'd0;
                                n_off   = 64'd0;
                                n_phase = PH_LENGTH;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_ls      <= 4'd0;
            r_os      <= 4'd0;
            r_fi      <= 4'd0;
            r_len     <= 64'd0;
            r_off     <= 64'd0;
            r_cc      <= 64'd0;
            r_idx     <= '0;
            r_fin     <= 1'b0;
            r_newlist <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (i_beat) begin
                r_phase   <= n_phase;
                r_ls      <= n_ls;
                r_os      <= n_os;
                r_fi      <= n_fi;
                r_len     <= n_len;
                r_off     <= n_off;
                r_cc      <= n_cc;
                r_idx     <= n_idx;
                r_fin     <= n_fin;
                r_newlist <= emit ? 1'b0 : (r_newlist | i_list_start);
            end
            r_valid <= (r_valid && !i_take) || (i_beat && emit);
            if (i_beat && emit) begin
                r_item <= n_item;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/drld_scale.sv]
// Two-stage 64x22 scaling: split partial products, then recombine mod 2^64.
module drld_scale (
    input  logic                         i_clk,
    input  logic                         i_en_mul,
    input  logic                         i_en_sum,
    input  logic [drld_pkg::WORD_W-1:0]  i_value,
    input  logic [drld_pkg::CB_W-1:0]    i_factor,
    output logic [drld_pkg::WORD_W-1:0]  o_product
);

    logic [53:0]                  r_lo;
    logic [31:0]                  r_hi;
    logic [drld_pkg::WORD_W-1:0]  r_prod;
    logic [53:0]                  n_lo;
    logic [31:0]                  n_hi;
    logic [drld_pkg::WORD_W-1:0]  n_prod;

    assign n_lo   = {22'd0, i_value[31:0]} * {32'd0, i_factor};
    assign n_hi   = i_value[63:32] * {10'd0, i_factor};
    assign n_prod = {10'd0, r_lo} + {r_hi, 32'd0};

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_en_sum) begin
            r_prod <= n_prod;
        end
    end

    assign o_product = r_prod;

endmodule

[rtl/data_run_list_decoder.sv]
// Run-list decoder top: config registers, scaling pipeline, limit check, output beat.
// Throughput: one byte beat per cycle, sustained, as long as the output is not stalled.
// Path: the byte beat that completes a run loads the parse slot; the result then passes partial
// products, recombine, and limit add and compare before it is offered as a result beat.
// Reset (synchronous, active low) clears parse state, produced total and all valids;
// config registers return to 4096-byte clusters, no limit and a 1 MiB byte cap.
`include "data_run_list_decoder_assert.svh"

module data_run_list_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_run_byte,
    input  logic                              i_list_start,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [drld_pkg::WORD_W-1:0]       o_start_byte,
    output logic [drld_pkg::WORD_W-1:0]       o_length_byte,
    output logic                              o_sparse,
    output logic [2:0]                        o_status,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [drld_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [drld_pkg::WORD_W-1:0]       i_cfg_data
);

    logic [drld_pkg::CB_W-1:0]    r_cluster_bytes;
    logic [drld_pkg::WORD_W-1:0]  r_alloc_limit;
    logic [drld_pkg::IDX_W-1:0]   r_byte_cap;

    logic                         s1_valid;
    drld_pkg::t_item              s1_item;
    logic                         r_v2, r_v3;
    drld_pkg::t_tag               r_tag2, r_tag3;
    logic [drld_pkg::WORD_W-1:0]  prod_len, prod_start;

    logic [drld_pkg::WORD_W-1:0]  r_total;
    logic                         r_squash;
    logic                         r_out_valid;
    logic [drld_pkg::WORD_W-1:0]  r_start, r_len;
    logic                         r_sparse, r_last;
    logic [2:0]                   r_status;

    logic                         out_ready, ready3, ready2, ready1;
    logic                         beat, adv12, adv23, fire;
    logic [drld_pkg::WORD_W-1:0]  base_total, tot_sum;
    logic                         base_squash, limit_hit;

    logic                         term_beat, term_clean, sparse_beat, ext_beat;
    logic                         limit_beat, limit_fire, drop_armed;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign ready3     = !r_v3 || out_ready;
    assign ready2     = !r_v2 || ready3;
    assign ready1     = !s1_valid || ready2;
    assign o_in_stall = !ready1;
    assign beat       = i_in_valid && ready1;
    assign adv12      = s1_valid && ready2;
    assign adv23      = r_v2 && ready3;
    assign fire       = r_v3 && out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_bytes <= drld_pkg::CB_W'(4096);
            r_alloc_limit   <= '0;
            r_byte_cap      <= drld_pkg::CAP_DEFAULT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                drld_pkg::CFG_CLUSTER_BYTES: r_cluster_bytes <= i_cfg_data[drld_pkg::CB_W-1:0];
                drld_pkg::CFG_ALLOC_LIMIT:   r_alloc_limit   <= i_cfg_data;
                drld_pkg::CFG_BYTE_CAP:      r_byte_cap      <= i_cfg_data[drld_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    drld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat       (beat),
        .i_run_byte   (i_run_byte),
        .i_list_start (i_list_start),
        .i_byte_cap   (r_byte_cap),
        .i_take       (adv12),
        .o_valid      (s1_valid),
        .o_item       (s1_item)
    );

    drld_scale u_scale_len (
        .i_clk     (i_clk),
        .i_en_mul  (adv12),
        .i_en_sum  (adv23),
        .i_value   (s1_item.len),
        .i_factor  (r_cluster_bytes),
        .o_product (prod_len)
    );

    drld_scale u_scale_start (
        .i_clk     (i_clk),
        .i_en_mul  (adv12),
        .i_en_sum  (adv23),
        .i_value   (s1_item.clus),
        .i_factor  (r_cluster_bytes),
        .o_product (prod_start)
    );

    // a new list restarts the produced total and lifts the post-limit drop
    assign base_total  = r_tag3.newlist ? '0 : r_total;
    assign base_squash = r_tag3.newlist ? 1'b0 : r_squash;
    assign tot_sum     = base_total + prod_len;
    assign limit_hit   = (r_alloc_limit != '0) && (tot_sum >= r_alloc_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_total     <= '0;
            r_squash    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v2 <= adv12 || (r_v2 && !ready3);
            r_v3 <= adv23 || (r_v3 && !out_ready);
            if (adv12) begin
                r_tag2 <= s1_item.tag;
            end
            if (adv23) begin
                r_tag3 <= r_tag2;
            end
            if (fire) begin
                r_total     <= r_tag3.ext ? tot_sum : base_total;
                r_squash    <= base_squash | (r_tag3.ext & limit_hit);
                r_out_valid <= !base_squash;
                r_start     <= prod_start;
                r_len       <= prod_len;
                r_sparse    <= r_tag3.sparse;
                if (r_tag3.ext) begin
                    r_status <= limit_hit ? drld_pkg::ST_LIMIT : drld_pkg::ST_EXTENT;
                    r_last   <= limit_hit;
                end else begin
                    r_status <= r_tag3.status;
                    r_last   <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_start_byte  = r_start;
    assign o_length_byte = r_len;
    assign o_sparse      = r_sparse;
    assign o_status      = r_status;
    assign o_last        = r_last;

    assign term_beat   = o_out_valid &&
                         (o_status inside {drld_pkg::ST_END, drld_pkg::ST_MALFORMED,
                                           drld_pkg::ST_CAP});
    assign term_clean  = o_last && !o_sparse && (o_start_byte == '0) && (o_length_byte == '0);
    assign sparse_beat = o_out_valid && o_sparse;
    assign ext_beat    = o_out_valid && (o_status inside {drld_pkg::ST_EXTENT, drld_pkg::ST_LIMIT});
    assign limit_beat  = (o_status == drld_pkg::ST_LIMIT);
    assign limit_fire  = fire && !base_squash && r_tag3.ext && limit_hit;
    assign drop_armed  = r_squash && o_out_valid && o_last;

    `DRLD_ASSERT_NOW(a_term_fields, term_beat, term_clean, "terminal beat with payload")
    `DRLD_ASSERT_NOW(a_sparse_start, sparse_beat, o_start_byte == '0, "sparse start nonzero")
    `DRLD_ASSERT_NOW(a_last_status, ext_beat, o_last == limit_beat, "last flag mismatch")
    `DRLD_ASSERT_NEXT(a_limit_drop, limit_fire, drop_armed, "limit beat not final")

endmodule

[verif/tb_data_run_list_decoder.sv]
// Self-checking testbench for the run-list decoder: directed table, random lists, config sweeps.
module tb_data_run_list_decoder;

    typedef enum logic [1:0] {PH_HEADER, PH_LENGTH, PH_OFFSET} t_parse_phase;

    typedef struct {
        logic [63:0] start_b;
        logic [63:0] len_b;
        logic        sparse;
        logic [2:0]  status;
        logic        last;
    } t_extent;

    typedef struct {
        logic [7:0] b;
        logic       s;
        bit         typed;
        t_extent    want;
    } t_script_row;

    localparam t_extent NO_EXT = '{64'd0, 64'd0, 1'b0, drld_pkg::ST_EXTENT, 1'b0};
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 160;

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_in_valid   = 1'b0;
    logic                           o_in_stall;
    logic [7:0]                     i_run_byte   = 8'd0;
    logic                           i_list_start = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall  = 1'b0;
    logic [drld_pkg::WORD_W-1:0]    o_start_byte;
    logic [drld_pkg::WORD_W-1:0]    o_length_byte;
    logic                           o_sparse;
    logic [2:0]                     o_status;
    logic                           o_last;
    logic                           i_cfg_we     = 1'b0;
    logic [drld_pkg::CFG_IDX_W-1:0] i_cfg_idx    = drld_pkg::CFG_CLUSTER_BYTES;
    logic [drld_pkg::WORD_W-1:0]    i_cfg_data   = '0;

    data_run_list_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_run_byte    (i_run_byte),
        .i_list_start  (i_list_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_start_byte  (o_start_byte),
        .o_length_byte (o_length_byte),
        .o_sparse      (o_sparse),
        .o_status      (o_status),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // decoder mirror: config and parse state
    logic [21:0]  cfg_cluster;
    logic [63:0]  cfg_limit;
    logic [20:0]  cfg_cap;
    t_parse_phase ph;
    logic [3:0]   len_sz;
    logic [3:0]   off_sz;
    logic [3:0]   fidx;
    logic [63:0]  run_len;
    logic [63:0]  off_val;
    logic [63:0]  cur_clus;
    logic [63:0]  produced;
    logic [20:0]  sidx;
    logic         done;

    t_extent     expected_extents[$];
    t_extent     mon_want;
    int unsigned error_count;
    int unsigned beats_checked;
    int unsigned bytes_taken;
    int unsigned bytes_ignored;
    int unsigned settings_count;
    int unsigned status_seen [8];
    int unsigned hold_cycles;
    bit          quiet;

    t_script_row script [25] = '{
        '{8'h00, 1'b1, 1'b1, '{64'd0, 64'd0, 1'b0, drld_pkg::ST_END, 1'b1}},
        '{8'h11, 1'b1, 1'b0, NO_EXT},
        '{8'hFF, 1'b0, 1'b0, NO_EXT},
        '{8'h80, 1'b0, 1'b1, '{64'hFFFF_FFFF_FFF8_0000, 64'h0000_0000_000F_F000, 1'b0,
                               drld_pkg::ST_EXTENT, 1'b0}},
        '{8'h01, 1'b0, 1'b0, NO_EXT},
        '{8'h00, 1'b0, 1'b1, '{64'd0, 64'd0, 1'b1, drld_pkg::ST_EXTENT, 1'b0}},
        '{8'h18, 1'b0, 1'b0, NO_EXT},
        '{8'hFF, 1'b0, 1'b0, NO_EXT},
        '{8'hFF, 1'b0, 1'b0, NO_EXT},
        '{8'hFF, 1'b0, 1'b0, NO_EXT},
        '{8'hFF, 1'b0, 1'b0, NO_EXT},
        '{8'hFF, 1'b0, 1'b0, NO_EXT},
        '{8'hFF, 1'b0, 1'b0, NO_EXT},
        '{8'hFF, 1'b0, 1'b0, NO_EXT},
        '{8'hFF, 1'b0, 1'b0, NO_EXT},
        '{8'h7F, 1'b0, 1'b1, '{64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_F000, 1'b0,
                               drld_pkg::ST_EXTENT, 1'b0}},
        '{8'h09, 1'b0, 1'b1, '{64'd0, 64'd0, 1'b0, drld_pkg::ST_MALFORMED, 1'b1}},
        '{8'h33, 1'b0, 1'b0, NO_EXT},
        '{8'h10, 1'b1, 1'b1, '{64'd0, 64'd0, 1'b0, drld_pkg::ST_MALFORMED, 1'b1}},
        '{8'h91, 1'b1, 1'b1, '{64'd0, 64'd0, 1'b0, drld_pkg::ST_MALFORMED, 1'b1}},
        '{8'h21, 1'b1, 1'b0, NO_EXT},
        '{8'h02, 1'b0, 1'b0, NO_EXT},
        '{8'h00, 1'b0, 1'b0, NO_EXT},
        '{8'h80, 1'b0, 1'b1, '{64'hFFFF_FFFF_F800_0000, 64'h0000_0000_0000_2000, 1'b0,
                               drld_pkg::ST_EXTENT, 1'b0}},
        '{8'h00, 1'b0, 1'b1, '{64'd0, 64'd0, 1'b0, drld_pkg::ST_END, 1'b1}}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic void clear_parse();
        ph       = PH_HEADER;
        len_sz   = '0;
        off_sz   = '0;
        fidx     = '0;
        run_len  = '0;
        off_val  = '0;
        cur_clus = '0;
        produced = '0;
        sidx     = '0;
        done     = 1'b0;
    endfunction

    function automatic t_extent close_run(input bit hole);
        t_extent r;
        r.len_b   = run_len * 64'(cfg_cluster);
        r.start_b = hole ? 64'd0 : cur_clus * 64'(cfg_cluster);
        r.sparse  = hole;
        produced  = produced + r.len_b;
        ph        = PH_HEADER;
        fidx      = '0;
        if (cfg_limit != 64'd0 && produced >= cfg_limit) begin
            done     = 1'b1;
            r.status = drld_pkg::ST_LIMIT;
            r.last   = 1'b1;
        end else begin
            r.status = drld_pkg::ST_EXTENT;
            r.last   = 1'b0;
        end
        return r;
    endfunction

    // one byte beat into the mirror; returns 1 when it closes out a result
    function automatic bit decode_byte(input logic [7:0] b, input logic s,
                                       output t_extent r, output bit taken);
        logic [20:0] cap;
        int          w;
        r     = NO_EXT;
        taken = 1'b0;
        if (s)
            clear_parse();
        if (done)
            return 1'b0;
        taken = 1'b1;
        if (ph == PH_LENGTH || ph == PH_OFFSET) begin
            if (sidx != drld_pkg::IDX_MAX)
                sidx++;
            if (ph == PH_LENGTH) begin
                run_len |= 64'(b) << {fidx[2:0], 3'b000};
                fidx++;
                if (fidx < len_sz)
                    return 1'b0;
                fidx = '0;
                if (off_sz == 4'd0) begin
                    r = close_run(1'b1);
                    return 1'b1;
                end
                ph = PH_OFFSET;
                return 1'b0;
            end
            off_val |= 64'(b) << {fidx[2:0], 3'b000};
            fidx++;
            if (fidx < off_sz)
                return 1'b0;
            if (off_sz < 4'd8) begin
                w = 8 * off_sz;
                if (off_val[w-1])
                    off_val |= ~64'd0 << w;
            end
            cur_clus = cur_clus + off_val;
            r = close_run(1'b0);
            return 1'b1;
        end
        ph  = PH_HEADER;
        cap = (cfg_cap == '0) ? drld_pkg::CAP_DEFAULT : cfg_cap;
        if (sidx >= cap) begin
            done = 1'b1;
            r    = '{64'd0, 64'd0, 1'b0, drld_pkg::ST_CAP, 1'b1};
            return 1'b1;
        end
        if (sidx != drld_pkg::IDX_MAX)
            sidx++;
        if (b == 8'd0) begin
            done = 1'b1;
            r    = '{64'd0, 64'd0, 1'b0, drld_pkg::ST_END, 1'b1};
            return 1'b1;
        end
        len_sz = b[3:0];
        off_sz = b[7:4];
        if (len_sz == 4'd0 || len_sz > drld_pkg::MAX_FIELD || off_sz > drld_pkg::MAX_FIELD) begin
            done = 1'b1;
            r    = '{64'd0, 64'd0, 1'b0, drld_pkg::ST_MALFORMED, 1'b1};
            return 1'b1;
        end
        fidx    = '0;
        run_len = '0;
        off_val = '0;
        ph      = PH_LENGTH;
        return 1'b0;
    endfunction

    task automatic offer_byte(input logic [7:0] b, input logic s, input bit typed,
                              input t_extent want);
        int      gap;
        bit      has;
        bit      taken;
        t_extent r;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_run_byte   <= b;
        i_list_start <= s;
        do @(posedge i_clk); while (o_in_stall);
        has = decode_byte(b, s, r, taken);
        if (taken)
            bytes_taken++;
        else
            bytes_ignored++;
        if (typed)
            expected_extents.insert(expected_extents.size(), want);
        else if (has)
            expected_extents.insert(expected_extents.size(), r);
    endtask

    task automatic send_list();
        int         runs;
        int         lsz;
        int         osz;
        logic [7:0] bad;
        runs = $urandom_range(1, 6);
        for (int k = 0; k < runs; k++) begin
            lsz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0)
                osz = 0;
            else
                osz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
            offer_byte({4'(osz), 4'(lsz)}, k == 0, 1'b0, NO_EXT);
            repeat (lsz + osz) offer_byte(8'($urandom), 1'b0, 1'b0, NO_EXT);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                offer_byte(8'h00, 1'b0, 1'b0, NO_EXT);
            end
            5: begin
                case ($urandom_range(0, 2))
                    0:       bad = {4'($urandom), 4'h0};
                    1:       bad = {4'($urandom), 4'($urandom_range(9, 15))};
                    default: bad = {4'($urandom_range(9, 15)), 4'($urandom)};
                endcase
                offer_byte(bad, 1'b0, 1'b0, NO_EXT);
            end
            6: begin
                offer_byte(8'h00, 1'b0, 1'b0, NO_EXT);
                repeat ($urandom_range(1, 4)) offer_byte(8'($urandom), 1'b0, 1'b0, NO_EXT);
            end
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
                offer_byte(8'($urandom), 1'($urandom_range(0, 3) == 0), 1'b0, NO_EXT);
    endtask

    task automatic drain_extents();
        for (int w = 0; w < 5000 && expected_extents.size() != 0; w++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [63:0] cb, input logic [63:0] lim,
                                  input logic [63:0] cap);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= drld_pkg::CFG_CLUSTER_BYTES;
        i_cfg_data <= cb;
        @(posedge i_clk);
        i_cfg_idx  <= drld_pkg::CFG_ALLOC_LIMIT;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_idx  <= drld_pkg::CFG_BYTE_CAP;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_cluster = cb[21:0];
        cfg_limit   = lim;
        cfg_cap     = cap[20:0];
        settings_count++;
    endtask

    // receiver: random stall per beat, plus one long hold-off on request
    initial begin
        int gap;
        forever begin
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            gap = quiet ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_checked++;
            status_seen[o_status]++;
            if (expected_extents.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                mon_want = expected_extents.pop_front();
                if (o_start_byte !== mon_want.start_b)
                    report_mismatch($sformatf("start_byte got %h want %h",
                                              o_start_byte, mon_want.start_b));
                if (o_length_byte !== mon_want.len_b)
                    report_mismatch($sformatf("length_byte got %h want %h",
                                              o_length_byte, mon_want.len_b));
                if (o_sparse !== mon_want.sparse)
                    report_mismatch($sformatf("sparse got %b want %b",
                                              o_sparse, mon_want.sparse));
                if (o_status !== mon_want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, mon_want.status));
                if (o_last !== mon_want.last)
                    report_mismatch($sformatf("last got %b want %b", o_last, mon_want.last));
            end
        end
    end

    initial begin
        logic [63:0] ph_cluster [NUM_PHASES];
        logic [63:0] ph_limit   [NUM_PHASES];
        logic [63:0] ph_cap     [NUM_PHASES];
        int unsigned mark;
        ph_cluster = '{64'd4096, 64'd1, 64'd2097152, 64'd512, 64'd0, 64'd4194303,
                       64'd4096, 64'd8, 64'd0, 64'd0};
        ph_limit   = '{64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd100000, 64'd1, 64'd0,
                       64'h0000_0001_0000_0000, 64'd0, 64'd0, 64'd0};
        ph_cap     = '{64'd1048576, 64'd0, 64'd1048576, 64'd60, 64'd1, 64'd2097151,
                       64'd25, 64'd300, 64'd0, 64'd0};
        cfg_cluster = 22'd4096;
        cfg_limit   = 64'd0;
        cfg_cap     = 21'd1048576;
        clear_parse();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                i_in_valid <= 1'b0;
                drain_extents();
                if (p >= 8) begin
                    ph_cluster[p] = $urandom_range(1, 4194303);
                    ph_limit[p]   = ($urandom_range(0, 2) == 0) ? 64'd0 :
                                    {$urandom, $urandom} >> $urandom_range(8, 63);
                    ph_cap[p]     = $urandom_range(1, 400);
                end
                apply_settings(ph_cluster[p], ph_limit[p], ph_cap[p]);
            end
            // one back-to-back phase; the receiver also stops for a long stretch
            quiet = (p == 4);
            if (p == 4)
                hold_cycles = 300;
            mark = bytes_taken + bytes_ignored;
            if (p == 0)
                foreach (script[i])
                    offer_byte(script[i].b, script[i].s, script[i].typed, script[i].want);
            while (bytes_taken + bytes_ignored - mark < PHASE_ITEMS)
                send_list();
        end
        i_in_valid <= 1'b0;
        quiet = 1'b0;
        drain_extents();
        repeat (20) @(posedge i_clk);
        if (expected_extents.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_extents.size()));

        $display("Decoded %0d bytes (%0d ignored after list end) over %0d register settings.",
                 bytes_taken, bytes_ignored, settings_count);
        $display("Checked %0d beats: extent %0d, end %0d, malformed %0d, cap %0d, limit %0d.",
                 beats_checked,
                 status_seen[drld_pkg::ST_EXTENT],
                 status_seen[drld_pkg::ST_END],
                 status_seen[drld_pkg::ST_MALFORMED],
                 status_seen[drld_pkg::ST_CAP],
                 status_seen[drld_pkg::ST_LIMIT]);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
